@@ rtl/core/ptdh_pkg.sv @@
package ptdh_pkg;

	localparam int NUM_BOARDS = 128;
	localparam int NUM_BINS   = 64;
	localparam int BIN_SHIFT  = 5;

	localparam int BOARD_W = 7;
	localparam int CHAN_W  = 4;
	localparam int TIME_W  = 11;
	localparam int BIN_W   = 6;
	localparam int COUNT_W = 32;

	localparam int HIST_AW    = 2 * BOARD_W + BIN_W;
	localparam int HIST_DEPTH = 1 << HIST_AW;

	typedef enum logic [1:0] {
		ACT_HIT   = 2'd0,
		ACT_CLOSE = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_READ  = 2'd3
	} act_t;

	typedef struct packed {
		act_t                 action;
		logic [BOARD_W-1:0]   board_index;
		logic [CHAN_W-1:0]    tdc_channel;
		logic [TIME_W-1:0]    coarse_time;
		logic [BOARD_W-1:0]   other_board;
		logic [BIN_W-1:0]     bin_index;
	} cmd_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               is_done;
	} res_t;

endpackage

@@ rtl/core/pairwise_time_difference_histogram.sv @@
// Pairwise time difference histogram. A word is taken at each clock edge where start is high
// and busy is low. Hit and read words leave busy low and may follow back to back; a read
// returns its counter on result, with result_valid high, in the cycle after it was taken. A
// close word walks all NUM_BOARDS^2 board pairs through a three-stage read-modify-write
// pipeline on the counter memory, one pair per cycle, then pulses result_valid with is_done
// set. A clear word zeroes the counter memory one entry per cycle, then pulses is_done. After
// reset the same clearing pass runs, with busy high throughout and no result. result_valid is
// a single-cycle strobe; it cannot be held off.
module pairwise_time_difference_histogram (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  ptdh_pkg::cmd_t        item,
	output logic                  result_valid,
	output ptdh_pkg::res_t        result
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_SWEEP
	} state_t;

	state_t                           state_q;
	logic [ptdh_pkg::BOARD_W-1:0]     i_q, j_q;
	logic [ptdh_pkg::HIST_AW-1:0]     clr_q;
	logic                             init_q;
	logic                             drain_q;
	logic                             done_q;
	logic [ptdh_pkg::NUM_BOARDS-1:0]  present_q;

	logic [ptdh_pkg::TIME_W-1:0]      tmem_a [ptdh_pkg::NUM_BOARDS];
	logic [ptdh_pkg::TIME_W-1:0]      tmem_b [ptdh_pkg::NUM_BOARDS];
	logic [ptdh_pkg::COUNT_W-1:0]     hmem   [ptdh_pkg::HIST_DEPTH];

	logic                             v_s1, v_s2;
	logic [ptdh_pkg::BOARD_W-1:0]     i_s1, j_s1;
	logic [ptdh_pkg::TIME_W-1:0]      ti_s1, tj_s1;
	logic [ptdh_pkg::HIST_AW-1:0]     addr_s1, addr_s2;
	logic [ptdh_pkg::COUNT_W-1:0]     hrd_q;

	logic                             rd_pend_q, rd_ok_q;

	logic                             accept;
	logic                             hit_ok;
	logic                             rd_ok;
	logic                             pair_v;
	logic                             i_last, j_last;
	logic [31:0]                      diff;
	logic [ptdh_pkg::BIN_W-1:0]       bin_s1;
	logic [ptdh_pkg::HIST_AW-1:0]     hist_raddr;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	assign hit_ok = (item.tdc_channel == '0) &&
		({1'b0, item.board_index} < (ptdh_pkg::BOARD_W + 1)'(ptdh_pkg::NUM_BOARDS));
	assign rd_ok  =
		({1'b0, item.board_index} < (ptdh_pkg::BOARD_W + 1)'(ptdh_pkg::NUM_BOARDS)) &&
		({1'b0, item.other_board} < (ptdh_pkg::BOARD_W + 1)'(ptdh_pkg::NUM_BOARDS)) &&
		({1'b0, item.bin_index} < (ptdh_pkg::BIN_W + 1)'(ptdh_pkg::NUM_BINS));

	assign i_last = (i_q == ptdh_pkg::BOARD_W'(ptdh_pkg::NUM_BOARDS - 1));
	assign j_last = (j_q == ptdh_pkg::BOARD_W'(ptdh_pkg::NUM_BOARDS - 1));
	assign pair_v = (state_q == ST_WALK) && present_q[i_q] && present_q[j_q];

	assign diff   = 32'(ti_s1) - 32'(tj_s1);
	assign bin_s1 = ptdh_pkg::BIN_W'((diff >> ptdh_pkg::BIN_SHIFT) &
		32'(ptdh_pkg::NUM_BINS - 1));
	assign addr_s1 = {i_s1, j_s1, bin_s1};

	assign hist_raddr = (state_q == ST_IDLE) ?
		{item.board_index, item.other_board, item.bin_index} : addr_s1;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_SWEEP;
			i_q       <= '0;
			j_q       <= '0;
			clr_q     <= '0;
			init_q    <= 1'b1;
			drain_q   <= 1'b0;
			done_q    <= 1'b0;
			present_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (item.action)
							ptdh_pkg::ACT_HIT: begin
								if (hit_ok)
									present_q[item.board_index] <= 1'b1;
							end
							ptdh_pkg::ACT_CLOSE: begin
								state_q <= ST_WALK;
								i_q     <= '0;
								j_q     <= '0;
							end
							ptdh_pkg::ACT_CLEAR: begin
								state_q <= ST_SWEEP;
								clr_q   <= '0;
								init_q  <= 1'b0;
							end
							ptdh_pkg::ACT_READ: begin
							end
							default: begin
							end
						endcase
					end
				end
				ST_WALK: begin
					j_q <= j_last ? '0 : j_q + 1'b1;
					if (j_last)
						i_q <= i_q + 1'b1;
					if (i_last && j_last) begin
						state_q   <= ST_DRAIN;
						drain_q   <= 1'b0;
						present_q <= '0;
					end
				end
				ST_DRAIN: begin
					drain_q <= 1'b1;
					if (drain_q) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				ST_SWEEP: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ptdh_pkg::HIST_AW'(ptdh_pkg::HIST_DEPTH - 1)) begin
						state_q <= ST_IDLE;
						done_q  <= !init_q;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// time stores, one read port each for the i and j sides of a pair
	always_ff @(posedge clk) begin
		if (accept && item.action == ptdh_pkg::ACT_HIT && hit_ok) begin
			tmem_a[item.board_index] <= item.coarse_time;
			tmem_b[item.board_index] <= item.coarse_time;
		end
		ti_s1 <= tmem_a[i_q];
		tj_s1 <= tmem_b[j_q];
	end

	// counter memory: read at s1, increment and write back at s2
	always_ff @(posedge clk) begin
		if (state_q == ST_SWEEP)
			hmem[clr_q] <= '0;
		else if (v_s2)
			hmem[addr_s2] <= hrd_q + 1'b1;
		hrd_q <= hmem[hist_raddr];
	end

	always_ff @(posedge clk) begin
		i_s1    <= i_q;
		j_s1    <= j_q;
		addr_s2 <= addr_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			rd_pend_q <= 1'b0;
			rd_ok_q   <= 1'b0;
		end else begin
			v_s1      <= pair_v;
			v_s2      <= v_s1;
			rd_pend_q <= accept && (item.action == ptdh_pkg::ACT_READ);
			rd_ok_q   <= rd_ok;
		end
	end

	assign result_valid   = done_q || rd_pend_q;
	assign result.count   = (rd_pend_q && rd_ok_q) ? hrd_q : '0;
	assign result.is_done = done_q;

endmodule

@@ rtl/core/ptdh_checker.sv @@
module ptdh_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input ptdh_pkg::cmd_t item,
	input logic           result_valid,
	input ptdh_pkg::res_t result
);

	logic take;

	assign take = start && !busy;

	a_read_answers: assert property (@(posedge clk) disable iff (!arst_n)
		take && item.action == ptdh_pkg::ACT_READ |=> result_valid && !result.is_done)
		else $error("read word gave no data word");

	a_hit_silent: assert property (@(posedge clk) disable iff (!arst_n)
		take && item.action == ptdh_pkg::ACT_HIT |=> !result_valid)
		else $error("hit word gave a result");

	a_long_busy: assert property (@(posedge clk) disable iff (!arst_n)
		take && (item.action == ptdh_pkg::ACT_CLOSE || item.action == ptdh_pkg::ACT_CLEAR)
		|=> busy && !result_valid)
		else $error("close or clear did not go busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.is_done |-> !busy && $past(busy))
		else $error("done strobe outside end of busy");

	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.is_done |-> result.count == '0)
		else $error("done strobe with nonzero count");

endmodule

bind pairwise_time_difference_histogram ptdh_checker u_ptdh_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.item         (item),
	.result_valid (result_valid),
	.result       (result)
);

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;

	localparam int N_RANDOM    = 1850;
	localparam int STALL_LIMIT = 5_000_000;
	localparam int TAIL_CYCLES = 50;

	class pair_hist_model;
		bit                          present[ptdh_pkg::NUM_BOARDS];
		logic [ptdh_pkg::TIME_W-1:0] latest[ptdh_pkg::NUM_BOARDS];
		int unsigned                 counts[int unsigned];
		int unsigned                 recent_keys[$];
		ptdh_pkg::res_t              pending_results[$];
		int                          errors;

		function void apply_word(ptdh_pkg::cmd_t w);
			ptdh_pkg::res_t r;
			int unsigned    d;
			int unsigned    bin;
			int unsigned    key;
			r = '0;
			case (w.action)
				ptdh_pkg::ACT_HIT: begin
					if (w.tdc_channel == 0 && w.board_index < ptdh_pkg::NUM_BOARDS) begin
						present[w.board_index] = 1'b1;
						latest[w.board_index]  = w.coarse_time;
					end
				end
				ptdh_pkg::ACT_CLOSE: begin
					for (int i = 0; i < ptdh_pkg::NUM_BOARDS; i++) begin
						for (int j = 0; j < ptdh_pkg::NUM_BOARDS; j++) begin
							if (present[i] && present[j]) begin
								// two's complement difference, logical shift on 32 bits
								d   = 32'(latest[i]) - 32'(latest[j]);
								bin = (d >> ptdh_pkg::BIN_SHIFT) & (ptdh_pkg::NUM_BINS - 1);
								key = 32'({ptdh_pkg::BOARD_W'(i), ptdh_pkg::BOARD_W'(j),
								           ptdh_pkg::BIN_W'(bin)});
								counts[key] = (counts.exists(key) ? counts[key] : 0) + 1;
								recent_keys.push_back(key);
								if (recent_keys.size() > 64)
									void'(recent_keys.pop_front());
							end
						end
					end
					foreach (present[b])
						present[b] = 1'b0;
					r.is_done = 1'b1;
				end
				ptdh_pkg::ACT_CLEAR: begin
					counts.delete();
					r.is_done = 1'b1;
				end
				default: begin
					key = 32'({w.board_index, w.other_board, w.bin_index});
					if (w.board_index < ptdh_pkg::NUM_BOARDS &&
					    w.other_board < ptdh_pkg::NUM_BOARDS &&
					    w.bin_index < ptdh_pkg::NUM_BINS && counts.exists(key))
						r.count = counts[key];
				end
			endcase
			if (w.action != ptdh_pkg::ACT_HIT)
				pending_results.push_back(r);
		endfunction

		function void compare_result(ptdh_pkg::res_t got);
			ptdh_pkg::res_t want;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected word: expected none, got count %h is_done %b",
				         $time, got.count, got.is_done);
			end else begin
				want = pending_results.pop_front();
				if (got.count !== want.count) begin
					errors++;
					$display("%0t: count mismatch: expected %h, got %h",
					         $time, want.count, got.count);
				end
				if (got.is_done !== want.is_done) begin
					errors++;
					$display("%0t: is_done mismatch: expected %b, got %b",
					         $time, want.is_done, got.is_done);
				end
			end
		endfunction
	endclass

	logic           clk;
	logic           arst_n;
	logic           start;
	logic           busy;
	ptdh_pkg::cmd_t item;
	logic           result_valid;
	ptdh_pkg::res_t result;

	pair_hist_model model;
	int             quiet_cycles;
	int             idle_by_phase[4] = '{0, 60, 0, 30};

	pairwise_time_difference_histogram i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid)
			model.compare_result(result);
	end

	always @(posedge clk) begin
		if ((start && !busy) || result_valid) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb failed");
				$finish;
			end
		end
	end

	function automatic ptdh_pkg::cmd_t random_word(ptdh_pkg::act_t a);
		ptdh_pkg::cmd_t w;
		w.action      = a;
		w.board_index = ptdh_pkg::BOARD_W'($urandom_range(ptdh_pkg::NUM_BOARDS - 1));
		w.tdc_channel = ptdh_pkg::CHAN_W'($urandom_range((1 << ptdh_pkg::CHAN_W) - 1));
		w.coarse_time = ptdh_pkg::TIME_W'($urandom_range((1 << ptdh_pkg::TIME_W) - 1));
		w.other_board = ptdh_pkg::BOARD_W'($urandom_range(ptdh_pkg::NUM_BOARDS - 1));
		w.bin_index   = ptdh_pkg::BIN_W'($urandom_range(ptdh_pkg::NUM_BINS - 1));
		return w;
	endfunction

	function automatic ptdh_pkg::cmd_t make_word(ptdh_pkg::act_t a, int b, int ch, int t,
	                                             int ob, int bn);
		ptdh_pkg::cmd_t w;
		w.action      = a;
		w.board_index = ptdh_pkg::BOARD_W'(b);
		w.tdc_channel = ptdh_pkg::CHAN_W'(ch);
		w.coarse_time = ptdh_pkg::TIME_W'(t);
		w.other_board = ptdh_pkg::BOARD_W'(ob);
		w.bin_index   = ptdh_pkg::BIN_W'(bn);
		return w;
	endfunction

	task automatic send_word(input ptdh_pkg::cmd_t w);
		start <= 1'b1;
		item  <= w;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		model.apply_word(w);
	endtask

	task automatic pause_sender(input int pct);
		int n;
		if (pct > 0 && $urandom_range(99) < pct) begin
			n = $urandom_range(1, 6);
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic wait_results_drained();
		start <= 1'b0;
		@(posedge clk);
		while (model.pending_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		ptdh_pkg::cmd_t               w;
		int                           sent;
		int                           phase;
		int                           len;
		int                           roll;
		int unsigned                  key;
		logic [ptdh_pkg::TIME_W-1:0]  base;
		logic [ptdh_pkg::BOARD_W-1:0] pool[8];

		model        = new();
		arst_n       = 1'b0;
		start        = 1'b0;
		item         = '0;
		quiet_cycles = 0;
		foreach (pool[p])
			pool[p] = ptdh_pkg::BOARD_W'($urandom_range(ptdh_pkg::NUM_BOARDS - 1));
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed
		send_word(make_word(ptdh_pkg::ACT_READ, 0, 0, 0, 0, 0));
		send_word(make_word(ptdh_pkg::ACT_CLOSE, 0, 0, 0, 0, 0));
		send_word(make_word(ptdh_pkg::ACT_HIT, 0, 0, 0, 0, 0));
		send_word(make_word(ptdh_pkg::ACT_HIT, 127, 0, 2047, 0, 0));
		send_word(make_word(ptdh_pkg::ACT_HIT, 5, 15, 100, 0, 0));
		send_word(make_word(ptdh_pkg::ACT_HIT, 64, 0, 1000, 0, 0));
		send_word(make_word(ptdh_pkg::ACT_HIT, 64, 0, 33, 0, 0));
		send_word(make_word(ptdh_pkg::ACT_CLOSE, 127, 15, 2047, 127, 63));
		send_word(make_word(ptdh_pkg::ACT_READ, 127, 0, 0, 0, 63));
		send_word(make_word(ptdh_pkg::ACT_READ, 0, 0, 0, 127, 0));
		send_word(make_word(ptdh_pkg::ACT_READ, 0, 0, 0, 0, 0));
		send_word(make_word(ptdh_pkg::ACT_READ, 64, 0, 0, 0, 1));
		send_word(make_word(ptdh_pkg::ACT_READ, 0, 0, 0, 64, 62));
		send_word(make_word(ptdh_pkg::ACT_READ, 64, 0, 0, 64, 0));
		send_word(make_word(ptdh_pkg::ACT_READ, 127, 15, 2047, 127, 63));
		send_word(make_word(ptdh_pkg::ACT_HIT, 9, 0, 500, 0, 0));
		wait_results_drained();
		send_word(make_word(ptdh_pkg::ACT_CLEAR, 127, 15, 2047, 127, 63));
		send_word(make_word(ptdh_pkg::ACT_READ, 127, 0, 0, 0, 63));
		send_word(make_word(ptdh_pkg::ACT_CLOSE, 0, 0, 0, 0, 0));
		send_word(make_word(ptdh_pkg::ACT_READ, 9, 0, 0, 9, 0));
		send_word(make_word(ptdh_pkg::ACT_READ, 0, 0, 0, 0, 0));

		// random events
		sent  = 0;
		phase = 0;
		while (sent < N_RANDOM) begin
			if (sent * 4 / N_RANDOM != phase) begin
				phase = sent * 4 / N_RANDOM;
				wait_results_drained();
			end
			base = ptdh_pkg::TIME_W'($urandom_range((1 << ptdh_pkg::TIME_W) - 1));
			len  = $urandom_range(0, 70);
			for (int k = 0; k < len; k++) begin
				w    = random_word(ptdh_pkg::ACT_HIT);
				roll = $urandom_range(9);
				if (roll == 0) begin
					if ($urandom_range(1))
						w.action = ptdh_pkg::ACT_READ;
				end else if (roll <= 3) begin
					w.action = ptdh_pkg::ACT_READ;
					if (model.recent_keys.size() != 0 && $urandom_range(3) != 0) begin
						key = model.recent_keys[$urandom_range(model.recent_keys.size() - 1)];
						{w.board_index, w.other_board, w.bin_index} = key[ptdh_pkg::HIST_AW-1:0];
					end
				end else begin
					w.tdc_channel = '0;
					if ($urandom_range(4) != 0)
						w.board_index = pool[$urandom_range(7)];
					w.coarse_time = ptdh_pkg::TIME_W'(base + $urandom_range(300));
				end
				pause_sender(idle_by_phase[phase]);
				send_word(w);
				if (!(w.action == ptdh_pkg::ACT_HIT && w.tdc_channel != 0))
					sent++;
			end
			if ($urandom_range(9) != 0) begin
				pause_sender(idle_by_phase[phase]);
				send_word(random_word(ptdh_pkg::ACT_CLOSE));
				sent++;
			end
		end

		wait_results_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (model.errors == 0 && model.pending_results.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
